// ===== hw/rtl/edf_pkg.sv =====
// ---------------------------------------------------------------------------
// edf_pkg: shared types and codes for the EDF task scheduler
// Command, status and task place codes plus the channel payload structs.
// ---------------------------------------------------------------------------
`default_nettype none

package edf_pkg;

  // task numbers travel as 4-bit fields, so the task table is fixed at 16
  localparam int TASKS = 16;

  localparam logic [2:0] CMD_CREATE   = 3'd0;
  localparam logic [2:0] CMD_SLEEP    = 3'd1;
  localparam logic [2:0] CMD_SET_DL   = 3'd2;
  localparam logic [2:0] CMD_TERM     = 3'd3;
  localparam logic [2:0] CMD_BLOCK    = 3'd4;
  localparam logic [2:0] CMD_RELEASE  = 3'd5;
  localparam logic [2:0] CMD_TICK     = 3'd6;
  localparam logic [2:0] CMD_SET_TICK = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_STATE = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;

  localparam logic [1:0] PLACE_FREE    = 2'd0;
  localparam logic [1:0] PLACE_READY   = 2'd1;
  localparam logic [1:0] PLACE_SLEEP   = 2'd2;
  localparam logic [1:0] PLACE_BLOCKED = 2'd3;

  // list codes, also the upper address bits of the order memory
  localparam logic [1:0] LST_READY   = 2'd0;
  localparam logic [1:0] LST_SLEEP   = 2'd1;
  localparam logic [1:0] LST_BLOCKED = 2'd2;

  // key memory bank select
  localparam logic KEY_DEADLINE = 1'b0;
  localparam logic KEY_WAKE     = 1'b1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  task_id;
    logic [31:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0]  running_task;
    logic        running_valid;
    logic [3:0]  previous_task;
    logic        switched;
    logic [1:0]  status;
    logic [31:0] tick_now;
    logic [4:0]  released_count;
  } result_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/edf_task_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// edf_task_scheduler_unit: earliest deadline first kernel scheduler
//
// Commands arrive as items on the in_ channel (valid/ready); each one gives
// exactly one result item on the out_ channel. Three sorted lists (ready by
// deadline, sleep by wake tick, blocked by deadline) live in one order
// memory, task deadlines and wake ticks in one key memory, both with a
// registered read port. A sequencer walks the lists one entry at a time.
// A sorted insert walks back from the list tail, shifting each entry it
// passes, a removal moves up every entry behind the removed one, and a
// tick command repeats that work for each task it releases.
// One command is in progress at a time; in_ready is high while the
// sequencer is idle, also while a result still waits in the output
// register. If the receiver stalls, the finished result of the next
// command is held until the output register frees up.
// Reset empties all lists, frees every task and zeroes the tick counter;
// the memories need no clearing.
// ---------------------------------------------------------------------------
`default_nettype none

module edf_task_scheduler_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  edf_pkg::cmd_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output edf_pkg::result_item_t out_data
);
  import edf_pkg::*;

  localparam int IDW = $clog2(TASKS);
  localparam int CW  = IDW + 1;
  localparam int OAW = IDW + 2;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_RM_CHK  = 4'd2;
  localparam logic [3:0] S_RM_W    = 4'd3;
  localparam logic [3:0] S_POST    = 4'd4;
  localparam logic [3:0] S_KEY_W   = 4'd5;
  localparam logic [3:0] S_INS_CHK = 4'd6;
  localparam logic [3:0] S_INS_W1  = 4'd7;
  localparam logic [3:0] S_INS_W2  = 4'd8;
  localparam logic [3:0] S_TK_CHK  = 4'd9;
  localparam logic [3:0] S_TK_W1   = 4'd10;
  localparam logic [3:0] S_TK_W2   = 4'd11;
  localparam logic [3:0] S_FIN     = 4'd12;
  localparam logic [3:0] S_FIN_W   = 4'd13;

  logic [3:0]     state_r, state_nxt;
  logic [2:0]     cmd_r, cmd_nxt;
  logic [3:0]     tid_r, tid_nxt;
  logic [31:0]    val_r, val_nxt;
  logic [IDW-1:0] id_r, id_nxt;
  logic [IDW-1:0] ent_r, ent_nxt;
  logic [31:0]    key_r, key_nxt;
  logic [1:0]     list_r, list_nxt;
  logic [CW-1:0]  i_r, i_nxt;
  logic           found_r, found_nxt;
  logic           phase_r, phase_nxt;
  logic [IDW-1:0] prev_task_r, prev_task_nxt;
  logic           prev_valid_r, prev_valid_nxt;
  logic [1:0]     status_r, status_nxt;
  logic [4:0]     rel_r, rel_nxt;
  logic [31:0]    tick_r, tick_nxt;
  logic [CW-1:0]  cnt_r [4];
  logic [CW-1:0]  cnt_nxt [4];
  logic [1:0]     place_r [TASKS];
  logic           out_valid_r, out_valid_nxt;
  result_item_t   out_data_r, out_data_nxt;

  logic           place_we;
  logic [IDW-1:0] place_wa;
  logic [1:0]     place_wd;

  logic           ord_we, ord_re;
  logic [OAW-1:0] ord_waddr, ord_raddr;
  logic [IDW-1:0] ord_wdata, ord_rdata;
  logic           key_we, key_re;
  logic [IDW:0]   key_waddr, key_raddr;
  logic [31:0]    key_wdata, key_rdata;

  logic           tid_ok;
  logic [IDW-1:0] tid_idx;
  logic [1:0]     tk_list;
  logic           tk_sel;
  logic           out_free;
  logic           now_valid;
  logic [IDW-1:0] now_task;

  edf_ram #(.WIDTH(IDW), .DEPTH(4 * TASKS)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .re(ord_re), .raddr(ord_raddr), .rdata(ord_rdata)
  );

  edf_ram #(.WIDTH(32), .DEPTH(2 * TASKS)) u_key (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .re(key_re), .raddr(key_raddr), .rdata(key_rdata)
  );

  assign tid_ok    = 32'(tid_r) < TASKS;
  assign tid_idx   = IDW'(tid_r);
  assign tk_list   = phase_r ? LST_BLOCKED : LST_SLEEP;
  assign tk_sel    = phase_r ? KEY_DEADLINE : KEY_WAKE;
  assign out_free  = !out_valid_r || out_ready;
  assign now_valid = cnt_r[LST_READY] != '0;
  assign now_task  = now_valid ? ord_rdata : '0;
  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    tid_nxt        = tid_r;
    val_nxt        = val_r;
    id_nxt         = id_r;
    ent_nxt        = ent_r;
    key_nxt        = key_r;
    list_nxt       = list_r;
    i_nxt          = i_r;
    found_nxt      = found_r;
    phase_nxt      = phase_r;
    prev_task_nxt  = prev_task_r;
    prev_valid_nxt = prev_valid_r;
    status_nxt     = status_r;
    rel_nxt        = rel_r;
    tick_nxt       = tick_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    place_we       = 1'b0;
    place_wa       = id_r;
    place_wd       = PLACE_READY;
    ord_we         = 1'b0;
    ord_waddr      = {list_r, i_r[IDW-1:0]};
    ord_wdata      = id_r;
    ord_re         = 1'b0;
    ord_raddr      = {list_r, i_r[IDW-1:0]};
    key_we         = 1'b0;
    key_waddr      = {KEY_DEADLINE, id_r};
    key_wdata      = key_r;
    key_re         = 1'b0;
    key_raddr      = {KEY_DEADLINE, id_r};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_data.cmd;
          tid_nxt    = in_data.task_id;
          val_nxt    = in_data.value;
          status_nxt = ST_OK;
          rel_nxt    = '0;
          ord_re     = 1'b1;
          ord_raddr  = {LST_READY, {IDW{1'b0}}};
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        prev_valid_nxt = now_valid;
        prev_task_nxt  = now_task;
        case (cmd_r)
          CMD_CREATE: begin
            if (!tid_ok || place_r[tid_idx] != PLACE_FREE) begin
              status_nxt = ST_BAD_STATE;
              state_nxt  = S_FIN;
            end else begin
              key_we    = 1'b1;
              key_waddr = {KEY_DEADLINE, tid_idx};
              key_wdata = val_r;
              place_we  = 1'b1;
              place_wa  = tid_idx;
              place_wd  = PLACE_READY;
              id_nxt    = tid_idx;
              key_nxt   = val_r;
              list_nxt  = LST_READY;
              i_nxt     = cnt_r[LST_READY];
              state_nxt = S_INS_CHK;
            end
          end
          CMD_SLEEP, CMD_SET_DL, CMD_TERM, CMD_BLOCK: begin
            if (!now_valid) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_FIN;
            end else begin
              id_nxt    = ord_rdata;
              list_nxt  = LST_READY;
              found_nxt = 1'b1;
              i_nxt     = CW'(1);
              state_nxt = S_RM_CHK;
            end
          end
          CMD_RELEASE: begin
            if (!tid_ok || place_r[tid_idx] != PLACE_BLOCKED) begin
              status_nxt = ST_BAD_STATE;
              state_nxt  = S_FIN;
            end else begin
              id_nxt    = tid_idx;
              list_nxt  = LST_BLOCKED;
              found_nxt = 1'b0;
              i_nxt     = '0;
              state_nxt = S_RM_CHK;
            end
          end
          CMD_TICK: begin
            tick_nxt  = tick_r + 32'd1;
            phase_nxt = 1'b0;
            state_nxt = S_TK_CHK;
          end
          default: begin
            tick_nxt  = val_r;
            state_nxt = S_FIN;
          end
        endcase
      end
      S_RM_CHK: begin
        if (i_r == cnt_r[list_r]) begin
          cnt_nxt[list_r] = cnt_r[list_r] - CW'(1);
          state_nxt       = S_POST;
        end else begin
          ord_re    = 1'b1;
          state_nxt = S_RM_W;
        end
      end
      S_RM_W: begin
        // close the gap: every entry behind the removed one moves up
        if (found_r) begin
          ord_we    = 1'b1;
          ord_waddr = {list_r, IDW'(i_r - CW'(1))};
          ord_wdata = ord_rdata;
        end else if (ord_rdata == id_r) begin
          found_nxt = 1'b1;
        end
        i_nxt     = i_r + CW'(1);
        state_nxt = S_RM_CHK;
      end
      S_POST: begin
        place_we = 1'b1;
        case (cmd_r)
          CMD_SLEEP: begin
            key_nxt   = tick_r + val_r;
            key_we    = 1'b1;
            key_waddr = {KEY_WAKE, id_r};
            key_wdata = tick_r + val_r;
            place_wd  = PLACE_SLEEP;
            list_nxt  = LST_SLEEP;
            i_nxt     = cnt_r[LST_SLEEP];
            state_nxt = S_INS_CHK;
          end
          CMD_SET_DL: begin
            key_nxt   = val_r;
            key_we    = 1'b1;
            key_wdata = val_r;
            place_wd  = PLACE_READY;
            list_nxt  = LST_READY;
            i_nxt     = cnt_r[LST_READY];
            state_nxt = S_INS_CHK;
          end
          CMD_TERM: begin
            place_wd  = PLACE_FREE;
            state_nxt = S_FIN;
          end
          CMD_BLOCK: begin
            place_wd  = PLACE_BLOCKED;
            list_nxt  = LST_BLOCKED;
            key_re    = 1'b1;
            state_nxt = S_KEY_W;
          end
          default: begin
            place_wd  = PLACE_READY;
            list_nxt  = LST_READY;
            key_re    = 1'b1;
            state_nxt = S_KEY_W;
          end
        endcase
      end
      S_KEY_W: begin
        key_nxt   = key_rdata;
        i_nxt     = cnt_r[list_r];
        state_nxt = S_INS_CHK;
      end
      S_INS_CHK: begin
        // walk back from the tail, shifting entries with an equal or later key
        if (i_r == '0) begin
          ord_we          = 1'b1;
          cnt_nxt[list_r] = cnt_r[list_r] + CW'(1);
          state_nxt       = (cmd_r == CMD_TICK) ? S_TK_CHK : S_FIN;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = {list_r, IDW'(i_r - CW'(1))};
          state_nxt = S_INS_W1;
        end
      end
      S_INS_W1: begin
        ent_nxt   = ord_rdata;
        key_re    = 1'b1;
        key_raddr = {(list_r == LST_SLEEP) ? KEY_WAKE : KEY_DEADLINE, ord_rdata};
        state_nxt = S_INS_W2;
      end
      S_INS_W2: begin
        ord_we = 1'b1;
        if (key_rdata >= key_r) begin
          ord_wdata = ent_r;
          i_nxt     = i_r - CW'(1);
          state_nxt = S_INS_CHK;
        end else begin
          cnt_nxt[list_r] = cnt_r[list_r] + CW'(1);
          state_nxt       = (cmd_r == CMD_TICK) ? S_TK_CHK : S_FIN;
        end
      end
      S_TK_CHK: begin
        if (cnt_r[tk_list] == '0) begin
          phase_nxt = 1'b1;
          state_nxt = phase_r ? S_FIN : S_TK_CHK;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = {tk_list, {IDW{1'b0}}};
          state_nxt = S_TK_W1;
        end
      end
      S_TK_W1: begin
        id_nxt    = ord_rdata;
        key_re    = 1'b1;
        key_raddr = {tk_sel, ord_rdata};
        state_nxt = S_TK_W2;
      end
      S_TK_W2: begin
        if (key_rdata <= tick_r) begin
          rel_nxt   = rel_r + 5'd1;
          list_nxt  = tk_list;
          found_nxt = 1'b1;
          i_nxt     = CW'(1);
          state_nxt = S_RM_CHK;
        end else begin
          phase_nxt = 1'b1;
          state_nxt = phase_r ? S_FIN : S_TK_CHK;
        end
      end
      S_FIN: begin
        ord_re    = 1'b1;
        ord_raddr = {LST_READY, {IDW{1'b0}}};
        state_nxt = S_FIN_W;
      end
      S_FIN_W: begin
        // hold the result until the output register frees up
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.running_task   = 4'(now_task);
          out_data_nxt.running_valid  = now_valid;
          out_data_nxt.previous_task  = 4'(prev_task_r);
          out_data_nxt.switched       = (now_valid != prev_valid_r) ||
                                        (now_task != prev_task_r);
          out_data_nxt.status         = status_r;
          out_data_nxt.tick_now       = tick_r;
          out_data_nxt.released_count = rel_r;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tick_r      <= '0;
      for (int k = 0; k < 4; k++) begin
        cnt_r[k] <= '0;
      end
      for (int k = 0; k < TASKS; k++) begin
        place_r[k] <= PLACE_FREE;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tick_r      <= tick_nxt;
      cnt_r       <= cnt_nxt;
      if (place_we) begin
        place_r[place_wa] <= place_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    tid_r        <= tid_nxt;
    val_r        <= val_nxt;
    id_r         <= id_nxt;
    ent_r        <= ent_nxt;
    key_r        <= key_nxt;
    list_r       <= list_nxt;
    i_r          <= i_nxt;
    found_r      <= found_nxt;
    phase_r      <= phase_nxt;
    prev_task_r  <= prev_task_nxt;
    prev_valid_r <= prev_valid_nxt;
    status_r     <= status_nxt;
    rel_r        <= rel_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/edf_ram.sv =====
// ---------------------------------------------------------------------------
// edf_ram: generic simple dual port RAM
// One write port, one read port, read data registered and held when idle.
// ---------------------------------------------------------------------------
`default_nettype none

module edf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/edf_chk.sv =====
// ---------------------------------------------------------------------------
// edf_chk: port level checks for the EDF task scheduler
// Watches the result channel and the consistency of each result item.
// ---------------------------------------------------------------------------
`default_nettype none

module edf_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input edf_pkg::result_item_t out_data
);
  import edf_pkg::*;

  // a stalled item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.running_valid |-> out_data.running_task == 4'd0)
    else $error("running task set on empty ready list");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.running_task != out_data.previous_task |-> out_data.switched)
    else $error("task change not flagged");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.released_count == 5'd0 && out_data.switched == 1'b0)
    else $error("failed command changed the schedule");

endmodule

bind edf_task_scheduler_unit edf_chk u_edf_chk (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);

`default_nettype wire

// ===== tb/tb_edf_task_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// tb_edf_task_scheduler_unit: self-checking bench for the EDF task scheduler
// Drives directed and random kernel commands with random idle cycles on both
// channels and compares every result item with a cycle-free list model.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_edf_task_scheduler_unit;
  import edf_pkg::*;

  localparam int NTASK = 16;

  // Sorted-list model of the scheduler; keeps the expected result items.
  class edf_scoreboard;
    logic [3:0]  rdy_q[$];
    logic [3:0]  slp_q[$];
    logic [3:0]  blk_q[$];
    logic [31:0] dline[NTASK];
    logic [31:0] wake[NTASK];
    logic [1:0]  place[NTASK];
    logic [31:0] ticks;
    result_item_t pending_q[$];
    int errors;
    int mismatches;

    function void clear();
      rdy_q.delete();
      slp_q.delete();
      blk_q.delete();
      pending_q.delete();
      ticks = '0;
      for (int i = 0; i < NTASK; i++) begin
        place[i] = PLACE_FREE;
        dline[i] = '0;
        wake[i]  = '0;
      end
    endfunction

    // insert before the first entry with an equal or later key
    function void put_ready(logic [3:0] id);
      int pos;
      pos = 0;
      while (pos < rdy_q.size() && dline[rdy_q[pos]] < dline[id]) pos++;
      rdy_q.insert(pos, id);
      place[id] = PLACE_READY;
    endfunction

    function void put_blocked(logic [3:0] id);
      int pos;
      pos = 0;
      while (pos < blk_q.size() && dline[blk_q[pos]] < dline[id]) pos++;
      blk_q.insert(pos, id);
      place[id] = PLACE_BLOCKED;
    endfunction

    function void put_sleep(logic [3:0] id);
      int pos;
      pos = 0;
      while (pos < slp_q.size() && wake[slp_q[pos]] < wake[id]) pos++;
      slp_q.insert(pos, id);
      place[id] = PLACE_SLEEP;
    endfunction

    function void note_command(cmd_item_t c);
      result_item_t r;
      logic        was_valid;
      logic [3:0]  was_task;
      logic [3:0]  id;
      logic [1:0]  st;
      logic [4:0]  moved;
      was_valid = rdy_q.size() > 0;
      was_task  = was_valid ? rdy_q[0] : 4'd0;
      st = ST_OK;
      moved = '0;
      case (c.cmd)
        CMD_CREATE: begin
          if (place[c.task_id] != PLACE_FREE) st = ST_BAD_STATE;
          else begin
            dline[c.task_id] = c.value;
            put_ready(c.task_id);
          end
        end
        CMD_SLEEP, CMD_SET_DL, CMD_TERM, CMD_BLOCK: begin
          if (!was_valid) st = ST_EMPTY;
          else begin
            id = rdy_q.pop_front();
            if (c.cmd == CMD_SLEEP) begin
              wake[id] = ticks + c.value;
              put_sleep(id);
            end else if (c.cmd == CMD_SET_DL) begin
              dline[id] = c.value;
              put_ready(id);
            end else if (c.cmd == CMD_TERM) begin
              place[id] = PLACE_FREE;
            end else begin
              put_blocked(id);
            end
          end
        end
        CMD_RELEASE: begin
          if (place[c.task_id] != PLACE_BLOCKED) st = ST_BAD_STATE;
          else begin
            for (int i = 0; i < blk_q.size(); i++)
              if (blk_q[i] == c.task_id) begin
                blk_q.delete(i);
                break;
              end
            put_ready(c.task_id);
          end
        end
        CMD_TICK: begin
          ticks = ticks + 1;
          while (slp_q.size() > 0 && wake[slp_q[0]] <= ticks) begin
            put_ready(slp_q.pop_front());
            moved++;
          end
          while (blk_q.size() > 0 && dline[blk_q[0]] <= ticks) begin
            put_ready(blk_q.pop_front());
            moved++;
          end
        end
        default: ticks = c.value;
      endcase
      r.running_valid  = rdy_q.size() > 0;
      r.running_task   = r.running_valid ? rdy_q[0] : 4'd0;
      r.previous_task  = was_task;
      r.switched       = (r.running_valid != was_valid) || (r.running_task != was_task);
      r.status         = st;
      r.tick_now       = ticks;
      r.released_count = moved;
      pending_q.push_back(r);
    endfunction

    function void check_result(result_item_t got);
      result_item_t exp;
      if (pending_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result item %p", got);
        return;
      end
      exp = pending_q.pop_front();
      if (got !== exp) begin
        errors++;
        if (mismatches++ < 10) $display("mismatch: expected %p actual %p", exp, got);
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  cmd_item_t    in_data;
  logic         out_valid;
  logic         out_ready;
  result_item_t out_data;
  bit           calm;

  edf_scoreboard sched_sb;

  edf_task_scheduler_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // note accepted commands and check results at the same edge they move
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sched_sb.note_command(in_data);
    if (rst_n && out_valid && out_ready) sched_sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 28);
  end

  // valid drops only on idle cycles, so back to back items keep it high
  task automatic send_cmd(logic [2:0] cmd, logic [3:0] tid, logic [31:0] value);
    cmd_item_t c;
    c.cmd = cmd;
    c.task_id = tid;
    c.value = value;
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sched_sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // mostly a busy but sane task mix; value ranges stay near the tick count
  task automatic send_random_cmd();
    logic [2:0]  cmd;
    logic [31:0] v;
    int r;
    r = $urandom_range(99);
    if (r < 22) cmd = CMD_CREATE;
    else if (r < 32) cmd = CMD_SLEEP;
    else if (r < 42) cmd = CMD_SET_DL;
    else if (r < 50) cmd = CMD_TERM;
    else if (r < 60) cmd = CMD_BLOCK;
    else if (r < 70) cmd = CMD_RELEASE;
    else if (r < 96) cmd = CMD_TICK;
    else cmd = CMD_SET_TICK;
    case ($urandom_range(9))
      0: v = $urandom();
      1: v = 32'hFFFF_FFFF - $urandom_range(3);
      default: v = sched_sb.ticks + $urandom_range(12);
    endcase
    if (cmd == CMD_SLEEP && $urandom_range(9) != 0) v = $urandom_range(8);
    send_cmd(cmd, 4'($urandom_range(15)), v);
  endtask

  initial begin
    sched_sb = new();
    sched_sb.clear();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    calm = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty ready list, bad release, then fill and exercise each command
    send_cmd(CMD_SLEEP, 4'd0, 32'd1);
    send_cmd(CMD_SET_DL, 4'd0, 32'd5);
    send_cmd(CMD_TERM, 4'd0, 32'd0);
    send_cmd(CMD_BLOCK, 4'd0, 32'd0);
    send_cmd(CMD_RELEASE, 4'd3, 32'd0);
    send_cmd(CMD_TICK, 4'd0, 32'd0);
    send_cmd(CMD_CREATE, 4'd15, 32'hFFFF_FFFF);
    send_cmd(CMD_CREATE, 4'd0, 32'd0);
    send_cmd(CMD_CREATE, 4'd7, 32'd0);
    send_cmd(CMD_CREATE, 4'd0, 32'd9);
    send_cmd(CMD_BLOCK, 4'd0, 32'd0);
    send_cmd(CMD_RELEASE, 4'd0, 32'd0);
    send_cmd(CMD_BLOCK, 4'd0, 32'd0);
    send_cmd(CMD_SET_DL, 4'd0, 32'h8000_0000);
    send_cmd(CMD_SLEEP, 4'd0, 32'hFFFF_FFFF);
    send_cmd(CMD_SLEEP, 4'd0, 32'd2);
    send_cmd(CMD_TICK, 4'd0, 32'd0);
    send_cmd(CMD_TICK, 4'd0, 32'd0);
    send_cmd(CMD_SET_TICK, 4'd0, 32'hFFFF_FFFE);
    send_cmd(CMD_TICK, 4'd0, 32'd0);
    send_cmd(CMD_TICK, 4'd0, 32'd0);
    send_cmd(CMD_TERM, 4'd0, 32'd0);
    send_cmd(CMD_SET_TICK, 4'd0, 32'd0);

    // hold off until everything drained
    drain_results();

    for (int n = 0; n < 500; n++) begin
      calm = (n >= 200 && n < 260);
      if (n == 350) drain_results();
      send_random_cmd();
    end
    calm = 1'b0;

    drain_results();
    repeat (200) @(posedge clk);
    if (sched_sb.errors == 0 && sched_sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
